// File: rtl/cari_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cari_pkg
// Shared types, codes and sizes of the index compaction and remap block.
// ----------------------------------------------------------------------------
package cari_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int IDX_W       = 12;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_REMAP   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REMAP_ERR = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [31:0]      use_count;
    logic [IDX_W-1:0] first_old_index;
    logic [IDX_W-1:0] second_old_index;
  } in_item_t;

  typedef struct packed {
    logic             kept;
    logic [IDX_W-1:0] new_index;
    logic [IDX_W-1:0] first_new_index;
    logic [IDX_W-1:0] second_new_index;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ZERO,
    OP_LOAD,
    OP_FULL,
    OP_REMAP
  } op_kind_t;

  // One decoded operation handed from the front end to the back end.
  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              kept;
    logic [IDX_W-1:0]  idx;
    logic              range_a;
    logic              range_b;
  } op_t;

  typedef struct packed {
    logic             kept;
    logic [IDX_W-1:0] idx;
  } mem_word_t;

endpackage

// File: rtl/compact_and_remap_indices.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_and_remap_indices
// Compacts a table of entries by use count and remaps index pairs through it.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | command, use count, two indices
//   output  | out_valid, out_stall, out_data | kept, indices, status
//
// One transfer is accepted per cycle when the output keeps up; a result is
// held in a queue slot and then in the result register before it appears.
// The rate is set by the table memory: two reads per item and a write per load.
// Reset clears the load counters and the queue; the table itself is never
// cleared, because a slot is only used after it was written since restart.
// A four-entry queue between the decoder and the table lets the input keep
// taking transfers while the output is stalled, until the queue fills.
//
// The front end decodes each transfer and keeps the number of loaded entries
// and the next compacted index, so range checks and the table-full decision
// are made there in arrival order. The back end writes or reads the table
// and holds the result in a register until it is taken.
module compact_and_remap_indices (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cari_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cari_pkg::out_item_t out_data
);
  import cari_pkg::*;

  op_t  push_data, pop_data;
  logic push, pop, q_full, q_empty;

  assign in_stall = q_full;

  cari_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .q_full    (q_full),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  cari_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  cari_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/cari_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cari_front
// Decodes each input item, keeps the load counters and issues one operation.
// ----------------------------------------------------------------------------
module cari_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              q_full,
  input  cari_pkg::in_item_t in_data,
  output logic              push,
  output cari_pkg::op_t     push_data
);
  import cari_pkg::*;

  logic [CNT_W-1:0] loaded_count_r, loaded_count_nxt;
  logic [CNT_W-1:0] next_idx_r, next_idx_nxt;
  logic             table_full;
  logic             keep;

  assign push       = in_valid && !q_full;
  assign table_full = loaded_count_r >= CNT_W'(MAX_ENTRIES);
  assign keep       = in_data.use_count != 32'd0;

  always_comb begin
    loaded_count_nxt  = loaded_count_r;
    next_idx_nxt      = next_idx_r;
    push_data.kind    = OP_ZERO;
    push_data.addr_a  = in_data.first_old_index[ADDR_W-1:0];
    push_data.addr_b  = in_data.second_old_index[ADDR_W-1:0];
    push_data.kept    = keep;
    push_data.idx     = next_idx_r[IDX_W-1:0];
    push_data.range_a = CNT_W'(in_data.first_old_index) < loaded_count_r;
    push_data.range_b = CNT_W'(in_data.second_old_index) < loaded_count_r;
    unique case (in_data.cmd)
      CMD_RESTART: begin
        loaded_count_nxt = '0;
        next_idx_nxt     = '0;
      end
      CMD_LOAD: begin
        if (table_full) begin
          push_data.kind = OP_FULL;
        end else begin
          push_data.kind   = OP_LOAD;
          push_data.addr_a = loaded_count_r[ADDR_W-1:0];
          loaded_count_nxt = loaded_count_r + CNT_W'(1);
          if (keep) begin
            next_idx_nxt = next_idx_r + CNT_W'(1);
          end
        end
      end
      CMD_REMAP: begin
        push_data.kind = OP_REMAP;
      end
      default: begin
        push_data.kind = OP_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_count_r <= '0;
      next_idx_r     <= '0;
    end else if (push) begin
      loaded_count_r <= loaded_count_nxt;
      next_idx_r     <= next_idx_nxt;
    end
  end

endmodule

// File: rtl/cari_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cari_queue
// Small FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module cari_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cari_pkg::op_t push_data,
  input  logic          pop,
  output cari_pkg::op_t pop_data,
  output logic          full,
  output logic          empty
);
  import cari_pkg::*;

  op_t               slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = count_r == QCNT_W'(QDEPTH);
  assign empty    = count_r == '0;
  assign pop_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/cari_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cari_back
// Owns the remap table, carries out each operation and holds the result.
// ----------------------------------------------------------------------------
module cari_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cari_pkg::op_t       pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cari_pkg::out_item_t out_data
);
  import cari_pkg::*;

  mem_word_t mem [MAX_ENTRIES];
  mem_word_t rd_a_r, rd_b_r;
  op_t       op_r;
  logic      res_valid_r;
  logic      remap_ok;

  assign pop       = !q_empty && (!res_valid_r || !out_stall);
  assign out_valid = res_valid_r;

  // The write of a load lands before any later remap reads, since the
  // operations leave the queue in order, at most one per cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (pop_data.kind == OP_LOAD) begin
        mem[pop_data.addr_a] <= '{kept: pop_data.kept, idx: pop_data.idx};
      end
      rd_a_r <= mem[pop_data.addr_a];
      rd_b_r <= mem[pop_data.addr_b];
      op_r   <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (pop) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  assign remap_ok = op_r.range_a && rd_a_r.kept && op_r.range_b && rd_b_r.kept;

  always_comb begin
    out_data = '0;
    unique case (op_r.kind)
      OP_LOAD: begin
        out_data.kept      = op_r.kept;
        out_data.new_index = op_r.kept ? op_r.idx : '0;
        out_data.status    = ST_OK;
      end
      OP_FULL: begin
        out_data.status = ST_FULL;
      end
      OP_REMAP: begin
        if (remap_ok) begin
          out_data.first_new_index  = rd_a_r.idx;
          out_data.second_new_index = rd_b_r.idx;
          out_data.status           = ST_OK;
        end else begin
          out_data.status = ST_REMAP_ERR;
        end
      end
      default: begin
        out_data = '0;
      end
    endcase
  end

endmodule
